FILE: sv/sli_pkg.sv
`default_nettype none

package sli_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int VALUE_WIDTH_DEFAULT = 16;

    localparam int CMD_WIDTH    = 2;
    localparam int STATUS_WIDTH = 3;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REM_MIN = 2'd1,
        CMD_REM_MAX = 2'd2,
        CMD_REM_VAL = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    // Control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic evaluate;
        logic ins_go;
        logic rm_go;
        t_cmd cmd;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/sli_cell.sv
`default_nettype none

module sli_cell
    import sli_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [VALUE_WIDTH-1:0] i_cmd_value,
    input  wire logic [VALUE_WIDTH-1:0] i_prev_value,
    input  wire logic                   i_prev_valid,
    input  wire logic                   i_prev_ge,
    input  wire logic [VALUE_WIDTH-1:0] i_next_value,
    input  wire logic                   i_next_valid,
    output logic [VALUE_WIDTH-1:0]      o_value,
    output logic                        o_valid,
    output logic                        o_ge,
    output logic                        o_eq,
    output logic [VALUE_WIDTH-1:0]      o_tap
);

    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic                   r_valid, n_valid;
    logic                   r_ge, n_ge;
    logic                   r_rm, n_rm;
    logic                   r_eq, n_eq;
    logic                   r_last, n_last;

    // Evaluate: local flags against the command value and the right neighbor
    always_comb begin
        n_ge   = !r_valid || (r_value > i_cmd_value);
        n_eq   = r_valid && (r_value == i_cmd_value);
        n_last = r_valid && !i_next_valid;
        case (i_ctl.cmd)
            CMD_REM_MIN: n_rm = 1'b1;
            CMD_REM_MAX: n_rm = !i_next_valid;
            CMD_REM_VAL: n_rm = !r_valid || (r_value >= i_cmd_value);
            default:     n_rm = 1'b0;
        endcase
    end

    // Apply: shift right from the insertion point, or left over the removal region
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.ins_go) begin
            if (i_prev_ge) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else if (r_ge) begin
                n_value = i_cmd_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.rm_go && r_rm) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.evaluate) begin
            r_ge   <= n_ge;
            r_rm   <= n_rm;
            r_eq   <= n_eq;
            r_last <= n_last;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;
    assign o_tap   = r_last ? r_value : '0;

endmodule

`default_nettype wire

FILE: sv/sorted_list_insert_remove.sv
`default_nettype none

// Sorted list of up to DEPTH nonzero values, kept in ascending order.
// Command channel: i_command and i_value are taken at a rising edge with
// start high and busy low. Commands: insert (equal values go behind those
// already held), remove smallest, remove largest, remove first equal value.
// Result channel: o_status and o_removed_value are valid for one cycle while
// o_done is high; the receiver cannot stall, so there is no back pressure.
// o_removed_value is zero for inserts and for every failed command.
// Timing: an accepted command passes an evaluate state (every cell
// compares its entry with the value and its neighbor) and an apply state
// that shifts the row; o_done is registered from the apply state. busy is
// high through both states, so a new command is taken only once the last
// one has left the apply pass through the row of cells.
// Reset (synchronous, active low) empties the list and clears busy and
// o_done at once; no clearing pass is needed.

module sorted_list_insert_remove
    import sli_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CMD_WIDTH-1:0]    i_command,
    input  wire logic [VALUE_WIDTH-1:0]  i_value,
    output logic                         o_done,
    output logic [STATUS_WIDTH-1:0]      o_status,
    output logic [VALUE_WIDTH-1:0]       o_removed_value
);

    t_state                 r_state, n_state;
    t_cmd                   r_cmd;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_done, n_done;
    t_status                r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_removed, n_removed;

    t_cell_ctl              w_ctl;
    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    logic [VALUE_WIDTH-1:0] w_tap   [DEPTH];
    logic [DEPTH-1:0]       w_valid;
    logic [DEPTH-1:0]       w_ge;
    logic [DEPTH-1:0]       w_eq;
    logic [VALUE_WIDTH-1:0] w_max_value;
    logic                   w_found;
    logic                   w_full;
    logic                   w_empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_prev_value;
            logic                   w_prev_valid;
            logic                   w_prev_ge;
            logic [VALUE_WIDTH-1:0] w_next_value;
            logic                   w_next_valid;

            if (gi == 0) begin : g_head
                assign w_prev_value = '0;
                assign w_prev_valid = 1'b1;
                assign w_prev_ge    = 1'b0;
            end else begin : g_body
                assign w_prev_value = w_value[gi-1];
                assign w_prev_valid = w_valid[gi-1];
                assign w_prev_ge    = w_ge[gi-1];
            end

            if (gi == DEPTH-1) begin : g_tail
                assign w_next_value = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next_value = w_value[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            sli_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_cmd_value  (r_val),
                .i_prev_value (w_prev_value),
                .i_prev_valid (w_prev_valid),
                .i_prev_ge    (w_prev_ge),
                .i_next_value (w_next_value),
                .i_next_valid (w_next_valid),
                .o_value      (w_value[gi]),
                .o_valid      (w_valid[gi]),
                .o_ge         (w_ge[gi]),
                .o_eq         (w_eq[gi]),
                .o_tap        (w_tap[gi])
            );
        end
    endgenerate

    // Only the last held cell drives a nonzero tap
    always_comb begin
        w_max_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_max_value = w_max_value | w_tap[i];
        end
    end

    assign w_found = |w_eq;
    assign w_full  = w_valid[DEPTH-1];
    assign w_empty = !w_valid[0];

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_status    = r_status;
        n_removed   = r_removed;
        w_ctl.evaluate = 1'b0;
        w_ctl.ins_go   = 1'b0;
        w_ctl.rm_go    = 1'b0;
        w_ctl.cmd      = r_cmd;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                w_ctl.evaluate = 1'b1;
                n_state        = S_APPLY;
            end
            S_APPLY: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                n_status  = ST_OK;
                n_removed = '0;
                if (r_cmd == CMD_INSERT) begin
                    if (r_val == '0) begin
                        n_status = ST_INVALID;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.ins_go = 1'b1;
                    end
                end else if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_cmd == CMD_REM_MIN) begin
                    n_removed   = w_value[0];
                    w_ctl.rm_go = 1'b1;
                end else if (r_cmd == CMD_REM_MAX) begin
                    n_removed   = w_max_value;
                    w_ctl.rm_go = 1'b1;
                end else if (w_found) begin
                    n_removed   = r_val;
                    w_ctl.rm_go = 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_removed <= n_removed;
        if (start && !busy) begin
            r_cmd <= t_cmd'(i_command);
            r_val <= i_value;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;

    // Held entries always form a contiguous run from cell 0
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("valid cells not contiguous");

    a_done_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> o_done)
        else $error("no result after apply");

    a_done_only_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_APPLY)
        else $error("result without apply");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_removed_value == '0)
        else $error("failed command returned a value");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule

`default_nettype wire

FILE: tb/sv/tb_sorted_list_insert_remove.sv
module tb_sorted_list_insert_remove
    import sli_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = DEPTH_DEFAULT;
    localparam int VW          = VALUE_WIDTH_DEFAULT;
    localparam int N_PLAN      = 28;
    localparam int N_RANDOM    = 1650;
    localparam int CYCLE_LIMIT = 200_000;

    typedef struct {
        t_status         status;
        logic [VW-1:0]   removed;
    } t_outcome;

    typedef struct {
        t_cmd            cmd;
        logic [VW-1:0]   val;
        bit              typed;
        t_status         st;
        logic [VW-1:0]   rem;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_WIDTH-1:0]    i_command = CMD_INSERT;
    logic [VW-1:0]           i_value = '0;
    logic                    o_done;
    logic [STATUS_WIDTH-1:0] o_status;
    logic [VW-1:0]           o_removed_value;

    // Mirror of the list contents, updated on every accepted command
    logic [VW-1:0] mirror_vals [LIST_DEPTH];
    int            mirror_cnt = 0;

    t_outcome      outcome_q[$];
    int unsigned   err_cnt = 0;
    int unsigned   idle_pct = 0;
    int unsigned   cyc = 0;

    // Rows with typed = 0 are checked against the mirror instead
    t_row plan [N_PLAN] = '{
        '{CMD_REM_MIN, 16'h0000, 1'b1, ST_EMPTY,     16'h0000},
        '{CMD_REM_MAX, 16'h1234, 1'b1, ST_EMPTY,     16'h0000},
        '{CMD_REM_VAL, 16'h0005, 1'b1, ST_EMPTY,     16'h0000},
        '{CMD_INSERT,  16'h0000, 1'b1, ST_INVALID,   16'h0000},
        '{CMD_INSERT,  16'hFFFF, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h0001, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h8000, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h8000, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h7FFF, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h0002, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'hFFFE, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h1000, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h1000, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h0100, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'hAAAA, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h5555, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h0010, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'hC000, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h0003, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h00FF, 1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT,  16'h4242, 1'b1, ST_FULL,      16'h0000},
        // zero on a full list: invalid wins over full
        '{CMD_INSERT,  16'h0000, 1'b1, ST_INVALID,   16'h0000},
        '{CMD_REM_VAL, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000},
        '{CMD_REM_VAL, 16'h0004, 1'b1, ST_NOT_FOUND, 16'h0000},
        '{CMD_REM_MIN, 16'hFFFF, 1'b1, ST_OK,        16'h0001},
        '{CMD_REM_MAX, 16'h0000, 1'b1, ST_OK,        16'hFFFF},
        '{CMD_REM_VAL, 16'h8000, 1'b1, ST_OK,        16'h8000},
        '{CMD_REM_VAL, 16'h1000, 1'b0, ST_OK,        16'h0000}
    };

    sorted_list_insert_remove #(
        .DEPTH       (LIST_DEPTH),
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_removed_value (o_removed_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Close the gap left by a removed entry
    function automatic void drop_at(int pos);
        int k;
        for (k = pos; k + 1 < mirror_cnt; k++) begin
            mirror_vals[k] = mirror_vals[k + 1];
        end
        mirror_cnt--;
    endfunction

    function automatic t_outcome apply_cmd(t_cmd cmd, logic [VW-1:0] val);
        t_outcome res;
        int       pos;
        int       k;
        res.status  = ST_OK;
        res.removed = '0;
        if (cmd == CMD_INSERT) begin
            if (val == '0) begin
                res.status = ST_INVALID;
            end else if (mirror_cnt >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // equal values stay ahead of the new one
                pos = mirror_cnt;
                for (k = mirror_cnt - 1; k >= 0; k--) begin
                    if (mirror_vals[k] > val) pos = k;
                end
                for (k = mirror_cnt; k > pos; k--) begin
                    mirror_vals[k] = mirror_vals[k - 1];
                end
                mirror_vals[pos] = val;
                mirror_cnt++;
            end
        end else if (mirror_cnt == 0) begin
            res.status = ST_EMPTY;
        end else begin
            case (cmd)
                CMD_REM_MIN: begin
                    res.removed = mirror_vals[0];
                    drop_at(0);
                end
                CMD_REM_MAX: begin
                    res.removed = mirror_vals[mirror_cnt - 1];
                    mirror_cnt--;
                end
                default: begin
                    pos = -1;
                    for (k = mirror_cnt - 1; k >= 0; k--) begin
                        if (mirror_vals[k] == val) pos = k;
                    end
                    if (pos < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.removed = mirror_vals[pos];
                        drop_at(pos);
                    end
                end
            endcase
        end
        return res;
    endfunction

    // Hold start until the block takes the command, then record its outcome
    task automatic send_cmd(input t_cmd cmd, input logic [VW-1:0] val,
                            input bit typed, input t_outcome typed_out);
        t_outcome pred;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_cmd(cmd, val);
        outcome_q.push_back(typed ? typed_out : pred);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d removed %h",
                         $time, o_status, o_removed_value);
                err_cnt++;
            end else begin
                if (o_status !== outcome_q[0].status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, outcome_q[0].status, o_status);
                    err_cnt++;
                end
                if (o_removed_value !== outcome_q[0].removed) begin
                    $display("%0t: removed value expected %h actual %h",
                             $time, outcome_q[0].removed, o_removed_value);
                    err_cnt++;
                end
                void'(outcome_q.pop_front());
            end
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("tb_sorted_list_insert_remove: errors");
        $finish;
    end

    initial begin
        t_outcome      fixed;
        int unsigned   n;
        int unsigned   seg_left;
        int unsigned   mode;
        int unsigned   ins_lim;
        int unsigned   sel;
        t_cmd          c;
        logic [VW-1:0] v;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_PLAN; n++) begin
            fixed.status  = plan[n].st;
            fixed.removed = plan[n].rem;
            send_cmd(plan[n].cmd, plan[n].val, plan[n].typed, fixed);
        end

        // Alternate fill, drain and mixed stretches so full and empty recur
        seg_left = 0;
        mode     = 0;
        for (n = 0; n < N_RANDOM; n++) begin
            idle_pct = (n < N_RANDOM / 3) ? 0 : (n < 2 * N_RANDOM / 3) ? 71 : 22;
            if (seg_left == 0) begin
                seg_left = $urandom_range(60, 12);
                mode     = $urandom_range(2);
            end
            seg_left--;
            ins_lim = (mode == 0) ? 80 : (mode == 1) ? 15 : 50;
            if ($urandom_range(99) < ins_lim) c = CMD_INSERT;
            else c = t_cmd'($urandom_range(3, 1));
            sel = $urandom_range(19);
            case (c)
                CMD_INSERT: begin
                    if (sel == 0) v = '0;
                    else if (sel < 7) v = VW'($urandom_range(6, 1));
                    else if (sel == 7) v = '1;
                    else if (sel == 8) v = VW'(1);
                    else v = VW'($urandom_range(16'hFFFF, 1));
                end
                CMD_REM_VAL: begin
                    if (mirror_cnt > 0 && sel < 12)
                        v = mirror_vals[$urandom_range(mirror_cnt - 1)];
                    else if (sel == 12) v = '0;
                    else if (sel < 16) v = VW'($urandom_range(6, 1));
                    else v = VW'($urandom);
                end
                default: v = VW'($urandom);
            endcase
            send_cmd(c, v, 1'b0, fixed);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_sorted_list_insert_remove: clean");
        end else begin
            $display("tb_sorted_list_insert_remove: errors");
        end
        $finish;
    end

endmodule
